[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/itmr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmr_pkg
// Types and constants for the two-channel interval timer.
// ----------------------------------------------------------------------------
package itmr_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [7:0] PORT_CH0  = 8'h40;
   localparam logic [7:0] PORT_CH2  = 8'h42;
   localparam logic [7:0] PORT_CTRL = 8'h43;
   localparam logic [7:0] PORT_SYS  = 8'h61;

   // command byte fields
   localparam logic [1:0] SEL_CH0           = 2'd0;
   localparam logic [1:0] SEL_CH2           = 2'd2;
   localparam logic [1:0] ACC_LOHI          = 2'd3;
   localparam logic [2:0] MODE_ONESHOT      = 3'd0;
   localparam logic [2:0] MODE_SQUARE       = 3'd3;
   localparam logic [2:0] MODE_SQUARE_ALIAS = 3'd7;

   // port 0x61 bit positions
   localparam int SYS_GATE2_BIT = 0;
   localparam int SYS_SPK_BIT   = 1;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] port;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_irq;
      logic       gated_timer_out;
      logic       speaker_drive;
   } rsp_type;

   // per-channel events for one item, already qualified by the pipeline advance
   typedef struct packed {
      logic       cmd_wr;
      logic       cmd_square;
      logic       data_wr;
      logic [7:0] data;
      logic       sys_wr;
      logic       gate_old;
      logic       gate_new;
      logic       tick;
      logic       gate;
   } chan_ctl_type;

endpackage

[rtl/core/itmr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmr_req_if / itmr_rsp_if
// Valid/ready channels for timer requests and results.
// ----------------------------------------------------------------------------
interface itmr_req_if;
   import itmr_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface itmr_rsp_if;
   import itmr_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/interval_timer_two_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_timer_two_channel
// 8254-style timer subset: channels 0 and 2, modes 0 and 3, plus port 0x61.
// ----------------------------------------------------------------------------
// One item (port write, port read or input clock tick) is accepted every
// cycle while the result side keeps up. An item is held in the input register,
// updates both channels and port 0x61 in a single pass, and its result is
// then loaded into the result register, which offers it on the result port;
// one result per cycle is sustained while the result side keeps taking them.
module interval_timer_two_channel #(
   parameter int COUNTER_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   itmr_req_if.sink          req_chan,
   itmr_rsp_if.source        rsp_chan
);
   import itmr_pkg::*;

   logic         in_valid_ff;
   req_type      in_data_ff;
   logic         out_valid_ff;
   rsp_type      out_data_ff, out_data_in;
   logic [3:0]   sys_ff, sys_in;

   logic         advance;
   logic         is_write, is_read, is_tick;
   logic [1:0]   sel;
   logic [1:0]   acc;
   logic [2:0]   mode;
   logic         cmd_ok;
   logic         lvl0_next, lvl2_next;
   chan_ctl_type ctl0, ctl2;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign is_write = advance && (in_data_ff.command == CMD_WRITE);
   assign is_read  = advance && (in_data_ff.command == CMD_READ);
   assign is_tick  = advance && (in_data_ff.command == CMD_TICK);

   assign sel  = in_data_ff.write_data[7:6];
   assign acc  = in_data_ff.write_data[5:4];
   assign mode = in_data_ff.write_data[3:1];

   always_comb begin
      cmd_ok = is_write && (in_data_ff.port == PORT_CTRL) && (sel inside {SEL_CH0, SEL_CH2})
               && (acc == ACC_LOHI) && !in_data_ff.write_data[0]
               && (mode inside {MODE_ONESHOT, MODE_SQUARE, MODE_SQUARE_ALIAS});
   end

   always_comb begin
      ctl0            = '0;
      ctl0.cmd_wr     = cmd_ok && (sel == SEL_CH0);
      ctl0.cmd_square = (mode != MODE_ONESHOT);
      ctl0.data_wr    = is_write && (in_data_ff.port == PORT_CH0);
      ctl0.data       = in_data_ff.write_data;
      ctl0.tick       = is_tick;
      ctl0.gate       = 1'b1;

      ctl2            = '0;
      ctl2.cmd_wr     = cmd_ok && (sel == SEL_CH2);
      ctl2.cmd_square = (mode != MODE_ONESHOT);
      ctl2.data_wr    = is_write && (in_data_ff.port == PORT_CH2);
      ctl2.data       = in_data_ff.write_data;
      ctl2.sys_wr     = is_write && (in_data_ff.port == PORT_SYS);
      ctl2.gate_old   = sys_ff[SYS_GATE2_BIT];
      ctl2.gate_new   = in_data_ff.write_data[SYS_GATE2_BIT];
      ctl2.tick       = is_tick;
      ctl2.gate       = sys_ff[SYS_GATE2_BIT];
   end

   itmr_channel #(.COUNTER_BITS(COUNTER_BITS)) u_ch0 (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl0),
      .level_next (lvl0_next)
   );

   itmr_channel #(.COUNTER_BITS(COUNTER_BITS)) u_ch2 (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl2),
      .level_next (lvl2_next)
   );

   assign sys_in = ctl2.sys_wr ? in_data_ff.write_data[3:0] : sys_ff;

   always_comb begin
      out_data_in.read_data       = '0;
      if (is_read && (in_data_ff.port == PORT_SYS)) begin
         out_data_in.read_data    = {2'b00, lvl2_next, 1'b0, sys_ff};
      end
      out_data_in.timer_irq       = lvl0_next;
      out_data_in.gated_timer_out = lvl2_next;
      out_data_in.speaker_drive   = lvl2_next & sys_in[SYS_SPK_BIT];
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_data_ff <= req_chan.data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sys_ff       <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         sys_ff <= sys_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

endmodule

[rtl/core/itmr_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmr_channel
// One timer channel: byte loading, mode 0 one-shot and mode 3 square wave.
// ----------------------------------------------------------------------------
module itmr_channel #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  itmr_pkg::chan_ctl_type ctl,
   output logic                   level_next
);
   import itmr_pkg::*;

   logic [COUNTER_BITS-1:0] counter_ff, counter_in;
   logic [COUNTER_BITS-1:0] reload_ff, reload_in;
   logic [7:0]              low_ff, low_in;
   logic                    expect_ff, expect_in;
   logic                    square_ff, square_in;
   logic                    counting_ff, counting_in;
   logic                    level_ff, level_in;

   logic [15:0]             full_word;
   logic [COUNTER_BITS-1:0] even_reload;
   logic [COUNTER_BITS-1:0] dec;

   assign full_word   = {ctl.data, low_ff};
   assign even_reload = {reload_ff[COUNTER_BITS-1:1], 1'b0};
   assign dec         = counter_ff - (square_ff ? COUNTER_BITS'(2) : COUNTER_BITS'(1));

   always_comb begin
      counter_in  = counter_ff;
      reload_in   = reload_ff;
      low_in      = low_ff;
      expect_in   = expect_ff;
      square_in   = square_ff;
      counting_in = counting_ff;
      level_in    = level_ff;
      if (ctl.cmd_wr) begin
         square_in   = ctl.cmd_square;
         counting_in = 1'b0;
         expect_in   = 1'b0;
         level_in    = ctl.cmd_square;
      end else if (ctl.data_wr) begin
         if (!expect_ff) begin
            low_in    = ctl.data;
            expect_in = 1'b1;
            if (!square_ff) begin
               counting_in = 1'b0;
            end
         end else begin
            expect_in   = 1'b0;
            reload_in   = full_word[COUNTER_BITS-1:0];
            counting_in = 1'b1;
            if (square_ff) begin
               counter_in = {full_word[COUNTER_BITS-1:1], 1'b0};
            end else begin
               counter_in = full_word[COUNTER_BITS-1:0];
               level_in   = 1'b0;
            end
         end
      end else if (ctl.sys_wr) begin
         if (square_ff) begin
            if (!ctl.gate_new) begin
               level_in = 1'b1;
            end else if (!ctl.gate_old && counting_ff) begin
               counter_in = even_reload;
            end
         end
      end else if (ctl.tick && counting_ff && ctl.gate) begin
         if (square_ff) begin
            if (dec == '0) begin
               level_in   = ~level_ff;
               counter_in = even_reload;
            end else begin
               counter_in = dec;
            end
         end else begin
            counter_in = dec;
            if (dec == '0) begin
               level_in = 1'b1;
            end
         end
      end
   end

   assign level_next = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff  <= '0;
         reload_ff   <= '0;
         low_ff      <= '0;
         expect_ff   <= 1'b0;
         square_ff   <= 1'b0;
         counting_ff <= 1'b0;
         level_ff    <= 1'b0;
      end else begin
         counter_ff  <= counter_in;
         reload_ff   <= reload_in;
         low_ff      <= low_in;
         expect_ff   <= expect_in;
         square_ff   <= square_in;
         counting_ff <= counting_in;
         level_ff    <= level_in;
      end
   end

endmodule

[rtl/core/itmr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmr_checker
// Port-level checks on the timer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itmr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input itmr_pkg::rsp_type rsp_data
);
   import itmr_pkg::*;

   logic stalled;
   logic past_reset_ff;
   logic req_seen;

   assign stalled  = rsp_valid && !rsp_ready;
   assign req_seen = req_valid && req_ready;

   always_ff @(posedge clock) begin
      past_reset_ff <= reset;
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_data))
   `ASSERT_IMPLY(a_spk_needs_out2, clock, reset, rsp_valid && rsp_data.speaker_drive, rsp_data.gated_timer_out)
   `ASSERT_IMPLY(a_read_bits, clock, reset, rsp_valid, (rsp_data.read_data[7:6] == 2'b00) && !rsp_data.read_data[4])
   `ASSERT_IMPLY(a_read_out2, clock, reset, rsp_valid && rsp_data.read_data[5], rsp_data.gated_timer_out)
   `ASSERT_IMPLY(a_idle_after_reset, clock, reset, past_reset_ff && !req_seen, !rsp_valid)

endmodule

bind interval_timer_two_channel itmr_checker u_itmr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
